// ----- hw/rtl/aperture_point_hit_test_defines.svh -----
// ----------------------------------------------------------------------------
// Aperture hit test: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef APERTURE_POINT_HIT_TEST_DEFINES_SVH
`define APERTURE_POINT_HIT_TEST_DEFINES_SVH

// The consequent is checked in the same cycle as the antecedent, so it may
// start with a fixed delay.
`define APHT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define APHT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/apht_pkg.sv -----
// ----------------------------------------------------------------------------
// Aperture hit test: shared package
// Field widths, shape and register codes, and the structs passed between
// the configuration registers and the two test units.
// ----------------------------------------------------------------------------
package apht_pkg;

	localparam int FIELD_W         = 32;
	localparam int RAD_W           = 31;
	localparam int RAD2_W          = 2 * RAD_W;
	localparam int VTX_COUNT       = 4;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_IDX_W       = 3;
	localparam int COORD_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		SHAPE_CIRCLE      = 3'd0,
		SHAPE_ANNULUS     = 3'd1,
		SHAPE_HEXAGON     = 3'd2,
		SHAPE_EQ_TRIANGLE = 3'd3,
		SHAPE_RECTANGLE   = 3'd4,
		SHAPE_TRIANGLE    = 3'd5,
		SHAPE_QUAD        = 3'd6
	} shape_t;

	// The one shape code that selects nothing.
	localparam logic [2:0] SHAPE_CODE_SPARE = 3'd7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHAPE_KIND    = 3'd0,
		REG_VERTEX_FIRST  = 3'd1,
		REG_VERTEX_SECOND = 3'd2,
		REG_VERTEX_THIRD  = 3'd3,
		REG_VERTEX_FOURTH = 3'd4,
		REG_OUTER_RADIUS  = 3'd5,
		REG_INNER_RADIUS  = 3'd6,
		REG_HALF_ARC      = 3'd7
	} reg_idx_t;

	typedef struct packed {
		shape_t                             shape;
		logic [VTX_COUNT-1:0][FIELD_W-1:0] vx;
		logic [VTX_COUNT-1:0][FIELD_W-1:0] vy;
		logic [RAD_W-1:0]                  outer_r;
		logic [RAD2_W-1:0]                 outer_r2;
		logic [RAD2_W-1:0]                 inner_r2;
		logic [FIELD_W-1:0]                arc_cos;
		logic [FIELD_W-1:0]                arc_sin;
	} apht_cfg_t;

	typedef struct packed {
		logic radius_miss;
		logic circle_hit;
		logic annulus_hit;
		logic hexagon_hit;
		logic triangle_hit;
	} apht_radial_t;

	typedef struct packed {
		logic rect_hit;
		logic tri_hit;
		logic quad_hit;
	} apht_poly_t;

endpackage

// ----- hw/rtl/apht_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Aperture hit test: configuration registers
// Holds the aperture description and the squared radii worked out on write.
// ----------------------------------------------------------------------------
module apht_cfg_regs #(
	parameter int COORD_WIDTH = apht_pkg::COORD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [apht_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [apht_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output apht_pkg::apht_cfg_t               cfg
);
	import apht_pkg::*;

	apht_cfg_t                cfg_q;
	logic signed [COORD_WIDTH-1:0] hi_c, lo_c;
	logic [FIELD_W-1:0]       hi_ext, lo_ext;
	logic [RAD_W-1:0]         rad_w;
	logic [RAD2_W-1:0]        rad_sq;

	// Coordinates are sign-extended from their low COORD_WIDTH bits.
	assign hi_c   = cfg_wdata[FIELD_W+COORD_WIDTH-1:FIELD_W];
	assign lo_c   = cfg_wdata[COORD_WIDTH-1:0];
	assign hi_ext = FIELD_W'(hi_c);
	assign lo_ext = FIELD_W'(lo_c);

	// Radii keep their low COORD_WIDTH-1 bits; both squares are stored.
	assign rad_w  = RAD_W'(cfg_wdata[COORD_WIDTH-2:0]);
	assign rad_sq = rad_w * rad_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SHAPE_KIND: begin
					cfg_q.shape <= shape_t'(cfg_wdata[2:0]);
				end
				REG_VERTEX_FIRST: begin
					cfg_q.vx[0] <= hi_ext;
					cfg_q.vy[0] <= lo_ext;
				end
				REG_VERTEX_SECOND: begin
					cfg_q.vx[1] <= hi_ext;
					cfg_q.vy[1] <= lo_ext;
				end
				REG_VERTEX_THIRD: begin
					cfg_q.vx[2] <= hi_ext;
					cfg_q.vy[2] <= lo_ext;
				end
				REG_VERTEX_FOURTH: begin
					cfg_q.vx[3] <= hi_ext;
					cfg_q.vy[3] <= lo_ext;
				end
				REG_OUTER_RADIUS: begin
					cfg_q.outer_r  <= rad_w;
					cfg_q.outer_r2 <= rad_sq;
				end
				REG_INNER_RADIUS: begin
					cfg_q.inner_r2 <= rad_sq;
				end
				REG_HALF_ARC: begin
					cfg_q.arc_cos <= cfg_wdata[CFG_DATA_W-1:FIELD_W];
					cfg_q.arc_sin <= cfg_wdata[FIELD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/apht_radial.sv -----
// ----------------------------------------------------------------------------
// Aperture hit test: radial shapes
// Circle, annular sector, hexagon and equilateral triangle tests on squared
// distances, centred on the origin.
// ----------------------------------------------------------------------------
module apht_radial #(
	parameter int COORD_WIDTH = apht_pkg::COORD_WIDTH_DEF
) (
	input  apht_pkg::apht_cfg_t           cfg,
	input  logic signed [COORD_WIDTH-1:0] pt_x,
	input  logic signed [COORD_WIDTH-1:0] pt_y,
	output apht_pkg::apht_radial_t        stat
);
	import apht_pkg::*;

	localparam int SQ_W  = 2 * COORD_WIDTH;
	localparam int CMP_W = 2 * COORD_WIDTH + 2;
	localparam int T_W   = COORD_WIDTH + 1;
	localparam int LS_W  = COORD_WIDTH + 2;
	localparam int PR_W  = FIELD_W + COORD_WIDTH;
	localparam int ARC_W = PR_W + 1;

	logic [COORD_WIDTH-1:0]        ax, ay;
	logic [SQ_W-1:0]               ax2, ay2;
	logic [CMP_W-1:0]              d2, r2, ri2, d2x4, r2x3, ay2x4, ax2x3, t2u, t2x3;
	logic [COORD_WIDTH-2:0]        rad;
	logic signed [T_W-1:0]         rad_s, ax_s, y_s, t_s;
	logic signed [2*T_W-1:0]       t2;
	logic signed [LS_W-1:0]        low_sum;
	logic signed [FIELD_W-1:0]     arc_c, arc_s;
	logic signed [PR_W-1:0]        cy, sx;
	logic signed [ARC_W-1:0]       sum_a, sum_b;
	logic miss, arc_ok, hex_near, hex_wide, hex_far_ok, hex_mid_ok;
	logic tri_near, tri_low, tri_far_ok;

	assign ax  = pt_x[COORD_WIDTH-1] ? $unsigned(-pt_x) : $unsigned(pt_x);
	assign ay  = pt_y[COORD_WIDTH-1] ? $unsigned(-pt_y) : $unsigned(pt_y);
	assign ax2 = ax * ax;
	assign ay2 = ay * ay;
	assign d2  = CMP_W'(ax2) + CMP_W'(ay2);
	assign r2  = CMP_W'(cfg.outer_r2);
	assign ri2 = CMP_W'(cfg.inner_r2);
	assign rad = cfg.outer_r[COORD_WIDTH-2:0];

	assign d2x4  = d2 << 2;
	assign r2x3  = (r2 << 1) + r2;
	assign ay2x4 = CMP_W'(ay2) << 2;
	assign ax2x3 = (CMP_W'(ax2) << 1) + CMP_W'(ax2);

	assign miss = d2 > r2;

	// Annular sector: wedge test on the half-arc cosine and sine.
	assign arc_c  = cfg.arc_cos;
	assign arc_s  = cfg.arc_sin;
	assign cy     = arc_c * pt_y;
	assign sx     = arc_s * pt_x;
	assign sum_a  = ARC_W'(cy) + ARC_W'(sx);
	assign sum_b  = ARC_W'(sx) - ARC_W'(cy);
	assign arc_ok = arc_c[FIELD_W-1] ? (!sum_a[ARC_W-1] || !sum_b[ARC_W-1])
	                                 : (!sum_a[ARC_W-1] && !sum_b[ARC_W-1]);

	// One squarer serves the outer edge of both polygons: the hexagon uses
	// the distance from its side vertex, the triangle the height above y.
	assign rad_s = T_W'(rad);
	assign ax_s  = T_W'(ax);
	assign y_s   = T_W'(pt_y);
	assign t_s   = (cfg.shape == SHAPE_EQ_TRIANGLE) ? (rad_s - y_s) : (rad_s - ax_s);
	assign t2    = t_s * t_s;
	assign t2u   = $unsigned(t2);
	assign t2x3  = (t2u << 1) + t2u;

	assign hex_near   = d2x4 <= r2x3;
	assign hex_wide   = (CMP_W'(ax) << 1) > CMP_W'(rad);
	assign hex_far_ok = CMP_W'(ay2) <= t2x3;
	assign hex_mid_ok = ay2x4 <= r2x3;

	assign low_sum    = (LS_W'(y_s) <<< 1) + LS_W'(rad_s);
	assign tri_near   = d2x4 <= r2;
	assign tri_low    = low_sum[LS_W-1];
	assign tri_far_ok = ax2x3 <= t2u;

	always_comb begin
		stat.radius_miss  = miss;
		stat.circle_hit   = !miss;
		stat.annulus_hit  = !miss && (d2 >= ri2) && arc_ok;
		stat.hexagon_hit  = !miss && (hex_near || (hex_wide ? hex_far_ok : hex_mid_ok));
		stat.triangle_hit = !miss && (tri_near || (!tri_low && tri_far_ok));
	end

endmodule

// ----- hw/rtl/apht_polygon.sv -----
// ----------------------------------------------------------------------------
// Aperture hit test: vertex shapes
// Axis-aligned rectangle, irregular triangle and irregular quadrilateral
// tests by comparisons and edge cross products.
// ----------------------------------------------------------------------------
module apht_polygon #(
	parameter int COORD_WIDTH = apht_pkg::COORD_WIDTH_DEF
) (
	input  apht_pkg::apht_cfg_t           cfg,
	input  logic signed [COORD_WIDTH-1:0] pt_x,
	input  logic signed [COORD_WIDTH-1:0] pt_y,
	output apht_pkg::apht_poly_t          stat
);
	import apht_pkg::*;

	localparam int D_W  = COORD_WIDTH + 1;
	localparam int P_W  = 2 * D_W;
	localparam int CR_W = P_W + 1;

	typedef struct packed {
		logic neg;
		logic nz;
	} cross_t;

	logic signed [COORD_WIDTH-1:0] vx [VTX_COUNT];
	logic signed [COORD_WIDTH-1:0] vy [VTX_COUNT];
	logic signed [D_W-1:0]         dx [VTX_COUNT];
	logic signed [D_W-1:0]         dy [VTX_COUNT];
	logic signed [D_W-1:0]         px, py, x_hi, y_hi;
	cross_t c12, c23, c31, c34, c41;
	logic n13;

	// Sign and non-zero flag of ax*by - bx*ay for the edge vectors a and b.
	function automatic cross_t cross_of(input logic signed [D_W-1:0] ax, ay, bx, by);
		logic signed [P_W-1:0]  p, q;
		logic signed [CR_W-1:0] d;
		cross_t                 r;
		p     = ax * by;
		q     = bx * ay;
		d     = CR_W'(p) - CR_W'(q);
		r.neg = d[CR_W-1];
		r.nz  = (d != '0);
		return r;
	endfunction

	assign px = D_W'(pt_x);
	assign py = D_W'(pt_y);

	always_comb begin
		for (int i = 0; i < VTX_COUNT; i++) begin
			vx[i] = cfg.vx[i][COORD_WIDTH-1:0];
			vy[i] = cfg.vy[i][COORD_WIDTH-1:0];
			dx[i] = D_W'(vx[i]) - px;
			dy[i] = D_W'(vy[i]) - py;
		end
	end

	// The rectangle keeps its corner in the first vertex and its lengths in
	// the second; a negative length leaves the far edge below the near one.
	assign x_hi = D_W'(vx[0]) + D_W'(vx[1]);
	assign y_hi = D_W'(vy[0]) + D_W'(vy[1]);

	assign c12 = cross_of(dx[0], dy[0], dx[1], dy[1]);
	assign c23 = cross_of(dx[1], dy[1], dx[2], dy[2]);
	assign c31 = cross_of(dx[2], dy[2], dx[0], dy[0]);
	assign c34 = cross_of(dx[2], dy[2], dx[3], dy[3]);
	assign c41 = cross_of(dx[3], dy[3], dx[0], dy[0]);

	// The diagonal from the first to the third vertex is the reverse of the
	// closing edge of the first triangle, so its sign flips unless it is zero.
	assign n13 = !c31.neg && c31.nz;

	always_comb begin
		stat.rect_hit = (D_W'(vx[0]) <= px) && (px <= x_hi) &&
		                (D_W'(vy[0]) <= py) && (py <= y_hi);
		stat.tri_hit  = (c12.neg == c23.neg) && (c23.neg == c31.neg);
		stat.quad_hit = stat.tri_hit || ((n13 == c34.neg) && (c34.neg == c41.neg));
	end

endmodule

// ----- hw/rtl/aperture_point_hit_test.sv -----
// ----------------------------------------------------------------------------
// Aperture point hit test
// Decides for each point whether it lies inside the configured aperture.
// ----------------------------------------------------------------------------
// Usage. The aperture is set up through the write port (cfg_we, cfg_index,
// cfg_wdata) while no item is in flight; a write lands at the clock edge at
// which cfg_we is high and takes effect for the next item. Points arrive on
// point_x and point_y and an item is taken at every edge with start high and
// busy low. busy never rises: the block takes a new point in every cycle.
// Each point passes through an input register, one pass of comparison and
// multiplier logic, and a result register. Its verdict is driven on
// inside_res with done high for one cycle, once the point has passed the
// result register, at a throughput of one item per cycle. The receiver
// cannot stall the block and must take each result as it appears.
// Reset (arst_n low) clears the item pipeline and sets every configuration
// register to zero, which selects a circle of radius zero. Coordinates are
// signed Q16.16, sign-extended from their low COORD_WIDTH bits.
// ----------------------------------------------------------------------------
module aperture_point_hit_test #(
	parameter int COORD_WIDTH = apht_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [apht_pkg::FIELD_W-1:0] point_x,
	input  logic signed [apht_pkg::FIELD_W-1:0] point_y,
	output logic                                done,
	output logic                                inside_res,
	input  logic                                cfg_we,
	input  logic [apht_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [apht_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import apht_pkg::*;

	`include "aperture_point_hit_test_defines.svh"

	apht_cfg_t                     cfg;
	apht_radial_t                  rad_stat;
	apht_poly_t                    poly_stat;
	logic signed [COORD_WIDTH-1:0] pt_x_s1, pt_y_s1;
	logic                          valid_s1;
	logic                          inside_q, done_q;
	logic                          hit;
	logic                          take;
	logic                          radial_miss;
	logic                          spare_shape;

	assign busy = 1'b0;
	assign take = start && !busy;

	apht_cfg_regs #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Input register: only the low COORD_WIDTH bits of each coordinate count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pt_x_s1 <= point_x[COORD_WIDTH-1:0];
			pt_y_s1 <= point_y[COORD_WIDTH-1:0];
		end
	end

	apht_radial #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_radial (
		.cfg  (cfg),
		.pt_x (pt_x_s1),
		.pt_y (pt_y_s1),
		.stat (rad_stat)
	);

	apht_polygon #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_polygon (
		.cfg  (cfg),
		.pt_x (pt_x_s1),
		.pt_y (pt_y_s1),
		.stat (poly_stat)
	);

	// Pick the verdict of the configured shape; the spare code hits nothing.
	always_comb begin
		case (cfg.shape)
			SHAPE_CIRCLE:      hit = rad_stat.circle_hit;
			SHAPE_ANNULUS:     hit = rad_stat.annulus_hit;
			SHAPE_HEXAGON:     hit = rad_stat.hexagon_hit;
			SHAPE_EQ_TRIANGLE: hit = rad_stat.triangle_hit;
			SHAPE_RECTANGLE:   hit = poly_stat.rect_hit;
			SHAPE_TRIANGLE:    hit = poly_stat.tri_hit;
			SHAPE_QUAD:        hit = poly_stat.quad_hit;
			default:           hit = 1'b0;
		endcase
	end

	// Result register: the strobe follows the input stage in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			inside_q <= hit;
		end
	end

	assign done       = done_q;
	assign inside_res = inside_q;

	// A point beyond the outer radius of a radial shape can never be inside.
	assign radial_miss = rad_stat.radius_miss &&
	                     (cfg.shape inside {SHAPE_CIRCLE, SHAPE_ANNULUS,
	                                        SHAPE_HEXAGON, SHAPE_EQ_TRIANGLE});
	assign spare_shape = (cfg.shape == SHAPE_CODE_SPARE);

	`APHT_ASSERT_NOW(a_item_gives_result, take, ##2 done, "item taken but no result")
	`APHT_ASSERT_NOW(a_result_has_item, done, $past(take, 2), "result without an item")
	`APHT_ASSERT_NEXT(a_radius_miss_out, valid_s1 && radial_miss, !inside_res, "outside radius hit")
	`APHT_ASSERT_NEXT(a_spare_shape_out, valid_s1 && spare_shape, !inside_res, "spare shape hit")

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Aperture point hit test: testbench
// Drives points and register writes into the hit test through a queue of
// pending items, predicts every verdict from its own copy of the aperture
// registers, and checks each result against the oldest prediction. A short
// directed pass covers each shape and its edge cases; randomised apertures
// follow, with idle gaps of random length between items.
// ----------------------------------------------------------------------------
module testbench;

	import apht_pkg::*;

	localparam int COORD_W = COORD_WIDTH_DEF;

	// One unit in Q16.16.
	localparam int Q = 65536;

	// cos(45 deg) and sin(45 deg) in Q1.30.
	localparam logic [31:0] ARC_45 = 32'h2D41_3CCD;

	// Cycles after the last result before the verdict, and the longest run
	// of cycles without any handshake that still counts as progress.
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 2000;

	// Wide enough for every product in the predictor without overflow.
	typedef logic signed [79:0] wide_t;

	// The predictor's copy of the configuration registers.
	typedef struct packed {
		logic [2:0]       shape;
		logic [3:0][63:0] vtx;
		logic [30:0]      outer_r;
		logic [30:0]      inner_r;
		logic [63:0]      arc;
	} aperture_regs_t;

	// One pending item for the driver: either a point or a register write.
	// gap is the number of idle cycles after the point has been taken.
	typedef struct packed {
		logic        is_write;
		reg_idx_t    index;
		logic [63:0] data;
		logic [31:0] px;
		logic [31:0] py;
		logic [7:0]  gap;
	} stim_t;

	logic                      clk        = 1'b0;
	logic                      arst_n     = 1'b0;
	logic                      start      = 1'b0;
	logic                      busy;
	logic signed [FIELD_W-1:0] point_x    = '0;
	logic signed [FIELD_W-1:0] point_y    = '0;
	logic                      done;
	logic                      inside_res;
	logic                      cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index  = '0;
	logic [CFG_DATA_W-1:0]     cfg_wdata  = '0;

	stim_t          stimulus[$];
	bit             inside_expected[$];
	aperture_regs_t aperture = '0;

	int  errors         = 0;
	int  points_taken   = 0;
	int  hits_predicted = 0;
	int  writes_done    = 0;
	int  apertures_run  = 0;
	int  gap_left       = 0;
	int  idle_run       = 0;
	int  stall_cycles   = 0;
	bit  burst          = 1'b0;

	aperture_point_hit_test #(
		.COORD_WIDTH(COORD_W)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.point_x   (point_x),
		.point_y   (point_y),
		.done      (done),
		.inside_res(inside_res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// A coordinate half is sign-extended from its low COORD_W bits.
	function automatic wide_t coord_of(logic [31:0] raw);
		wide_t w;
		w = {{(80 - COORD_W){raw[COORD_W-1]}}, raw[COORD_W-1:0]};
		return w;
	endfunction

	// Inside a triangle when the edge cross products, taken about the
	// point, share a sign; a cross product of zero counts as non-negative.
	// Three collinear corners therefore accept only the points on their line.
	function automatic bit in_tri(logic [63:0] p1, logic [63:0] p2, logic [63:0] p3,
			wide_t x, wide_t y);
		wide_t x1, y1, x2, y2, x3, y3;
		bit    n1, n2, n3;
		x1 = coord_of(p1[63:32]) - x;
		y1 = coord_of(p1[31:0]) - y;
		x2 = coord_of(p2[63:32]) - x;
		y2 = coord_of(p2[31:0]) - y;
		x3 = coord_of(p3[63:32]) - x;
		y3 = coord_of(p3[31:0]) - y;
		n1 = (x1 * y2 - x2 * y1) < 0;
		n2 = (x2 * y3 - x3 * y2) < 0;
		n3 = (x3 * y1 - x1 * y3) < 0;
		return (n1 == n2) && (n2 == n3);
	endfunction

	// Verdict for one point under the given registers. Radial shapes work on
	// squared distances; the sqrt(3) factors of the hexagon and the
	// equilateral triangle are removed by squaring both sides.
	function automatic bit predict_inside(aperture_regs_t regs, logic [31:0] px,
			logic [31:0] py);
		wide_t x, y, ax, ay, d2, rad, r2, ri, t, cosw, sinw, cy, sx;
		wide_t xl, yl, xu, yu;
		bit    a_ok, b_ok;
		x   = coord_of(px);
		y   = coord_of(py);
		ax  = (x < 0) ? -x : x;
		ay  = (y < 0) ? -y : y;
		d2  = ax * ax + ay * ay;
		rad = '0;
		rad[COORD_W-2:0] = regs.outer_r[COORD_W-2:0];
		ri  = '0;
		ri[COORD_W-2:0] = regs.inner_r[COORD_W-2:0];
		r2  = rad * rad;
		case (regs.shape)
			SHAPE_CIRCLE:
				return d2 <= r2;
			SHAPE_ANNULUS: begin
				// An inner radius beyond the outer one leaves nothing inside.
				if (d2 < ri * ri || d2 > r2)
					return 1'b0;
				cosw = {{48{regs.arc[63]}}, regs.arc[63:32]};
				sinw = {{48{regs.arc[31]}}, regs.arc[31:0]};
				cy   = cosw * y;
				sx   = sinw * x;
				a_ok = cy >= -sx;
				b_ok = sx >= cy;
				// Arcs wider than a half turn are the union of the two half planes.
				return (cosw >= 0) ? (a_ok && b_ok) : (a_ok || b_ok);
			end
			SHAPE_HEXAGON: begin
				if (d2 > r2)
					return 1'b0;
				if (4 * d2 <= 3 * r2)
					return 1'b1;
				if (2 * x > rad) begin
					t = rad - x;
					return ay * ay <= 3 * t * t;
				end
				if (2 * x >= -rad)
					return 4 * ay * ay <= 3 * r2;
				t = x + rad;
				return ay * ay <= 3 * t * t;
			end
			SHAPE_EQ_TRIANGLE: begin
				if (d2 > r2)
					return 1'b0;
				if (4 * d2 <= r2)
					return 1'b1;
				if (2 * y < -rad)
					return 1'b0;
				t = rad - y;
				return 3 * ax * ax <= t * t;
			end
			SHAPE_RECTANGLE: begin
				// A negative length leaves an empty rectangle.
				xl = coord_of(regs.vtx[0][63:32]);
				yl = coord_of(regs.vtx[0][31:0]);
				xu = xl + coord_of(regs.vtx[1][63:32]);
				yu = yl + coord_of(regs.vtx[1][31:0]);
				return xl <= x && x <= xu && yl <= y && y <= yu;
			end
			SHAPE_TRIANGLE:
				return in_tri(regs.vtx[0], regs.vtx[1], regs.vtx[2], x, y);
			SHAPE_QUAD:
				return in_tri(regs.vtx[0], regs.vtx[1], regs.vtx[2], x, y) ||
					in_tri(regs.vtx[0], regs.vtx[2], regs.vtx[3], x, y);
			default:
				return 1'b0;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Appends an item to the tail of the driver's queue.
	function automatic void queue_stim(stim_t entry);
		stimulus.insert(stimulus.size(), entry);
	endfunction

	// Appends a prediction to the tail of the queue of awaited results.
	function automatic void queue_verdict(bit verdict);
		inside_expected.insert(inside_expected.size(), verdict);
	endfunction

	function automatic logic [63:0] pack_xy(int x, int y);
		return {x, y};
	endfunction

	// Uniform in [-2^k, 2^k); k of 31 spans the whole field.
	function automatic int rnd_coord(int k);
		return $signed($urandom) >>> (31 - k);
	endfunction

	task automatic put_reg(reg_idx_t idx, logic [63:0] val);
		stim_t entry;
		entry          = '0;
		entry.is_write = 1'b1;
		entry.index    = idx;
		entry.data     = val;
		queue_stim(entry);
	endtask

	// Gaps are mostly absent or short, now and then long; a burst phase
	// sends its points back to back.
	task automatic put_point(int x, int y);
		stim_t entry;
		int    roll;
		entry    = '0;
		entry.px = x;
		entry.py = y;
		roll     = $urandom_range(0, 99);
		if (burst || roll < 50)
			entry.gap = '0;
		else if (roll < 85)
			entry.gap = 8'($urandom_range(1, 3));
		else if (roll < 97)
			entry.gap = 8'($urandom_range(4, 10));
		else
			entry.gap = 8'($urandom_range(20, 60));
		queue_stim(entry);
	endtask

	// ------------------------------------------------------------------
	// Driver
	// ------------------------------------------------------------------
	// Every handshake is observed at the rising edge. The predictor's copy
	// of the registers is updated at the edge on which a write lands, and a
	// point is predicted at the edge on which it is taken. Register writes
	// wait until every outstanding result has come back and the block has
	// been quiet, so no point in flight ever sees a change of aperture.
	always @(posedge clk) begin : drive_items
		logic  next_start;
		logic  next_we;
		stim_t head;
		next_start = start;
		next_we    = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				queue_verdict(predict_inside(aperture, point_x, point_y));
				points_taken++;
				if (inside_expected[$])
					hits_predicted++;
				next_start = 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SHAPE_KIND:    aperture.shape   = cfg_wdata[2:0];
					REG_VERTEX_FIRST:  aperture.vtx[0]  = cfg_wdata;
					REG_VERTEX_SECOND: aperture.vtx[1]  = cfg_wdata;
					REG_VERTEX_THIRD:  aperture.vtx[2]  = cfg_wdata;
					REG_VERTEX_FOURTH: aperture.vtx[3]  = cfg_wdata;
					REG_OUTER_RADIUS:  aperture.outer_r = cfg_wdata[30:0];
					REG_INNER_RADIUS:  aperture.inner_r = cfg_wdata[30:0];
					REG_HALF_ARC:      aperture.arc     = cfg_wdata;
					default: ;
				endcase
				writes_done++;
			end
			if (inside_expected.size() == 0 && !next_start)
				idle_run++;
			else
				idle_run = 0;
			if (!next_start) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (stimulus.size() != 0) begin
					head = stimulus[0];
					if (!head.is_write) begin
						void'(stimulus.pop_front());
						point_x    <= head.px;
						point_y    <= head.py;
						next_start = 1'b1;
						gap_left   = head.gap;
					end else if (idle_run >= 2) begin
						void'(stimulus.pop_front());
						cfg_index <= head.index;
						cfg_wdata <= head.data;
						next_we   = 1'b1;
					end
				end
			end
		end
		start  <= next_start;
		cfg_we <= next_we;
	end

	// ------------------------------------------------------------------
	// Monitor
	// ------------------------------------------------------------------
	// A result is valid for exactly the cycle in which done is high and is
	// taken at the edge that closes it; it must match the oldest prediction.
	always @(posedge clk) begin : check_results
		bit want;
		if (arst_n && done) begin
			if (inside_expected.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual inside_res=%0b",
					$time, inside_res);
				errors++;
			end else begin
				want = inside_expected.pop_front();
				if (inside_res !== want) begin
					$display("%0t: inside_res mismatch, expected %0b, actual %0b",
						$time, want, inside_res);
					errors++;
				end
			end
		end
	end

	// The run is abandoned when nothing has moved for too long.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (start && !busy) || done || cfg_we) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d results outstanding",
				$time, STALL_LIMIT, inside_expected.size());
			$display("testbench NOT OK");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin : sequence_run
		int          phase, n, k, pick, j;
		int          vx[4];
		int          vy[4];
		int          rad, rin, bx, by;
		logic [2:0]  shape_sel;
		logic [63:0] junk;

		// Straight out of reset the aperture is a circle of radius zero:
		// only the origin is inside.
		put_point(0, 0);
		put_point(1, 0);

		// Circle of radius ten, first on its rim and just outside it, then
		// with the widest radius; the write's spare upper bits are all ones.
		put_reg(REG_SHAPE_KIND, {61'd0, SHAPE_CIRCLE});
		put_reg(REG_OUTER_RADIUS, 64'(10 * Q));
		put_point(10 * Q, 0);
		put_point(10 * Q, 1);
		put_reg(REG_OUTER_RADIUS, '1);
		put_point(32'h7FFF_FFFF, 0);
		put_point(32'h8000_0000, 32'h8000_0000);

		// Annular sector of a quarter turn about the x axis, then three
		// quarters of a turn (negative cosine), then with the inner radius
		// above the outer one.
		put_reg(REG_SHAPE_KIND, {61'd0, SHAPE_ANNULUS});
		put_reg(REG_OUTER_RADIUS, 64'(10 * Q));
		put_reg(REG_INNER_RADIUS, 64'(5 * Q));
		put_reg(REG_HALF_ARC, {ARC_45, ARC_45});
		put_point(7 * Q, 0);
		put_point(0, 7 * Q);
		put_point(3 * Q, 0);
		put_reg(REG_HALF_ARC, {-ARC_45, ARC_45});
		put_point(0, 7 * Q);
		put_point(-7 * Q, 0);
		put_reg(REG_INNER_RADIUS, 64'(12 * Q));
		put_point(7 * Q, 0);

		// Hexagon and equilateral triangle of circumradius ten.
		put_reg(REG_SHAPE_KIND, {61'd0, SHAPE_HEXAGON});
		put_point(9 * Q, Q);
		put_point(0, 9 * Q);
		put_reg(REG_SHAPE_KIND, {61'd0, SHAPE_EQ_TRIANGLE});
		put_point(0, 10 * Q);
		put_point(0, -5 * Q);
		put_point(4 * Q, 4 * Q);

		// Rectangle: its far corner, just beyond it, then a negative width.
		put_reg(REG_SHAPE_KIND, {61'd0, SHAPE_RECTANGLE});
		put_reg(REG_VERTEX_FIRST, pack_xy(-2 * Q, -3 * Q));
		put_reg(REG_VERTEX_SECOND, pack_xy(4 * Q, 6 * Q));
		put_point(2 * Q, 3 * Q);
		put_point(2 * Q, 3 * Q + 1);
		put_reg(REG_VERTEX_SECOND, pack_xy(-Q, 6 * Q));
		put_point(-2 * Q, 0);

		// Right triangle: a point on the hypotenuse gives a zero cross
		// product. Then three collinear corners, which reject a point off their line.
		put_reg(REG_SHAPE_KIND, {61'd0, SHAPE_TRIANGLE});
		put_reg(REG_VERTEX_FIRST, pack_xy(0, 0));
		put_reg(REG_VERTEX_SECOND, pack_xy(10 * Q, 0));
		put_reg(REG_VERTEX_THIRD, pack_xy(0, 10 * Q));
		put_point(5 * Q, 5 * Q);
		put_point(5 * Q, 5 * Q + 1);
		put_reg(REG_VERTEX_THIRD, pack_xy(20 * Q, 0));
		put_point(3 * Q, -7 * Q);

		// Square as a quadrilateral: a corner and a point beside it.
		put_reg(REG_SHAPE_KIND, {61'd0, SHAPE_QUAD});
		put_reg(REG_VERTEX_THIRD, pack_xy(10 * Q, 10 * Q));
		put_reg(REG_VERTEX_FOURTH, pack_xy(0, 10 * Q));
		put_point(10 * Q, 10 * Q);
		put_point(11 * Q, 5 * Q);

		// The spare shape code rejects everything.
		put_reg(REG_SHAPE_KIND, {61'd0, SHAPE_CODE_SPARE});
		put_point(0, 0);
		apertures_run = 10;

		// Randomised apertures. Each one rewrites every register, with
		// random bits above the used ones, at a random scale from 1/256 of a
		// unit up to the full coordinate range.
		for (phase = 0; phase < 26; phase++) begin
			burst = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 7))
				0: k = 8;
				1: k = 12;
				2: k = 16;
				3: k = 20;
				4: k = 24;
				5: k = 28;
				6: k = 30;
				default: k = 31;
			endcase
			if ($urandom_range(0, 19) == 0)
				shape_sel = SHAPE_CODE_SPARE;
			else
				shape_sel = 3'($urandom_range(0, 6));
			for (j = 0; j < 4; j++) begin
				vx[j] = rnd_coord(k);
				vy[j] = rnd_coord(k);
			end
			// Rectangle lengths are mostly positive.
			if (shape_sel == SHAPE_RECTANGLE && $urandom_range(0, 99) < 85) begin
				vx[1] = int'($urandom >> (32 - k));
				vy[1] = int'($urandom >> (32 - k));
			end
			// Now and then a flat triangle: the third corner on the line
			// through the first two.
			if ($urandom_range(0, 99) < 8) begin
				vx[2] = 2 * vx[1] - vx[0];
				vy[2] = 2 * vy[1] - vy[0];
			end
			rad = int'($urandom >> (32 - k));
			if ($urandom_range(0, 9) == 0)
				rin = int'($urandom >> (32 - k));
			else
				rin = $urandom_range(0, rad);
			junk = {$urandom, $urandom};
			put_reg(REG_SHAPE_KIND, {junk[63:3], shape_sel});
			put_reg(REG_VERTEX_FIRST, pack_xy(vx[0], vy[0]));
			put_reg(REG_VERTEX_SECOND, pack_xy(vx[1], vy[1]));
			put_reg(REG_VERTEX_THIRD, pack_xy(vx[2], vy[2]));
			put_reg(REG_VERTEX_FOURTH, pack_xy(vx[3], vy[3]));
			junk = {$urandom, $urandom};
			put_reg(REG_OUTER_RADIUS, {junk[63:31], rad[30:0]});
			put_reg(REG_INNER_RADIUS, {junk[32:0], rin[30:0]});
			put_reg(REG_HALF_ARC, {$urandom, $urandom});
			apertures_run++;

			for (n = 0; n < 20; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 12) begin
					put_point($urandom, $urandom);
				end else if (pick < 35) begin
					// On or next to a corner or a rim point, one LSB off at most.
					j = $urandom_range(0, 3);
					if (shape_sel >= SHAPE_RECTANGLE) begin
						bx = vx[j];
						by = vy[j];
						if (shape_sel == SHAPE_RECTANGLE && j >= 1) begin
							bx = vx[0] + ((j != 2) ? vx[1] : 0);
							by = vy[0] + ((j != 1) ? vy[1] : 0);
						end
					end else begin
						bx = (j == 0) ? rad : (j == 1) ? -rad : 0;
						by = (j == 2) ? rad : (j == 3) ? -rad : 0;
					end
					put_point(bx + $urandom_range(0, 2) - 1, by + $urandom_range(0, 2) - 1);
				end else begin
					put_point(rnd_coord((k < 31) ? k + 1 : 31),
						rnd_coord((k < 31) ? k + 1 : 31));
				end
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Let everything drain, then give the block time to show any stray
		// result.
		while (stimulus.size() != 0 || start || cfg_we || inside_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d points (%0d predicted inside) under %0d apertures",
			points_taken, hits_predicted, apertures_run);
		$display("%0d register writes, %0d mismatches", writes_done, errors);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
